FILE: src/sled_pkg.sv
package sled_pkg;

    localparam int BUF_DEPTH   = 512;
    localparam int AW          = $clog2(BUF_DEPTH);
    localparam int FW          = AW + 1;
    localparam int MAX_RESULTS = 64;
    localparam int CW          = $clog2(MAX_RESULTS + 1);
    localparam int QDEPTH      = 2;

    localparam logic [1:0] CFG_START_MARKER = 2'd0;
    localparam logic [1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [1:0] CFG_OVERHEAD     = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_FRAME = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef struct packed {
        logic          is_read;
        logic [7:0]    data_byte;
        logic [AW-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [6:0] overhead;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_HEADW,
        ST_LENW,
        ST_ENDW,
        ST_RSA,
        ST_RSB,
        ST_FIN
    } t_state;

endpackage

FILE: src/sled_front.sv
module sled_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_req_type,
    input  logic [7:0]    i_data_byte,
    input  logic [8:0]    i_read_offset,
    output logic          o_q_valid,
    output sled_pkg::t_cmd o_q_cmd,
    input  logic          i_q_pop
);
    import sled_pkg::*;

    t_cmd       r_q [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cmd;

    assign o_ready   = (r_cnt < 2'(QDEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];

    always_comb begin
        cmd.is_read   = i_req_type;
        cmd.data_byte = i_data_byte;
        cmd.addr      = i_read_offset[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

FILE: src/sled_back.sv
module sled_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [7:0]     i_cfg_data,
    input  logic           i_q_valid,
    input  sled_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_result_kind,
    output logic [8:0]     o_frame_start,
    output logic [8:0]     o_frame_length,
    output logic [7:0]     o_read_byte,
    output logic           o_overflow_cleared,
    output logic           o_last_result
);
    import sled_pkg::*;

    logic [7:0]    r_mem [BUF_DEPTH];
    logic [7:0]    r_rd_data;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    t_cfg          r_cfg;
    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_k, n_k;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic [8:0]    r_len, n_len;
    logic          r_hold_v, n_hold_v;
    logic [8:0]    r_hold_start, n_hold_start;
    logic [8:0]    r_hold_len, n_hold_len;

    logic          r_ov, n_ov;
    t_kind         r_kind, n_kind;
    logic [8:0]    r_fs, n_fs;
    logic [8:0]    r_fl, n_fl;
    logic [7:0]    r_rb, n_rb;
    logic          r_of, n_of;
    logic          r_last, n_last;

    logic          out_free;
    logic [FW-1:0] fill_t;
    logic [8:0]    len;

    assign out_free           = !r_ov || i_ready;
    assign o_valid            = r_ov;
    assign o_result_kind      = r_kind;
    assign o_frame_start      = r_fs;
    assign o_frame_length     = r_fl;
    assign o_read_byte        = r_rb;
    assign o_overflow_cleared = r_of;
    assign o_last_result      = r_last;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= 8'd222;
            r_cfg.end_marker   <= 8'd202;
            r_cfg.overhead     <= 7'd24;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_MARKER: r_cfg.start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_cfg.end_marker   <= i_cfg_data;
                CFG_OVERHEAD:     r_cfg.overhead     <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_fill       = r_fill;
        n_k          = r_k;
        n_cnt        = r_cnt;
        n_ovf        = r_ovf;
        n_len        = r_len;
        n_hold_v     = r_hold_v;
        n_hold_start = r_hold_start;
        n_hold_len   = r_hold_len;
        n_ov         = r_ov && !i_ready;
        n_kind       = r_kind;
        n_fs         = r_fs;
        n_fl         = r_fl;
        n_rb         = r_rb;
        n_of         = r_of;
        n_last       = r_last;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = r_head;
        mem_raddr    = r_head;
        mem_wdata    = i_q_cmd.data_byte;
        o_q_pop      = 1'b0;
        fill_t       = (r_fill == FW'(BUF_DEPTH)) ? '0 : r_fill;
        len          = 9'(r_rd_data) + 9'(r_cfg.overhead);

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.is_read) begin
                        mem_re    = 1'b1;
                        mem_raddr = i_q_cmd.addr;
                        n_state   = ST_RD;
                    end else begin
                        n_ovf     = (r_fill == FW'(BUF_DEPTH));
                        mem_we    = 1'b1;
                        mem_waddr = r_head + fill_t[AW-1:0];
                        n_fill    = fill_t + FW'(1);
                        n_cnt     = '0;
                        n_hold_v  = 1'b0;
                        n_state   = ST_CHK;
                    end
                end
            end
            ST_RD: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_kind  = KIND_READ;
                    n_fs    = '0;
                    n_fl    = '0;
                    n_rb    = r_rd_data;
                    n_of    = 1'b0;
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_CHK: begin
                if (r_fill > FW'(2) && r_cnt < CW'(MAX_RESULTS)) begin
                    mem_re  = 1'b1;
                    n_state = ST_HEADW;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_HEADW: begin
                if (r_rd_data != r_cfg.start_marker) begin
                    n_k     = FW'(1);
                    n_state = ST_RSA;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_head + AW'(1);
                    n_state   = ST_LENW;
                end
            end
            ST_LENW: begin
                n_len = len;
                if (FW'(len) > r_fill) begin
                    n_state = ST_FIN;
                end else if (len == 9'd0) begin
                    n_k     = FW'(1);
                    n_state = ST_RSA;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_head + AW'(len) - AW'(1);
                    n_state   = ST_ENDW;
                end
            end
            ST_ENDW: begin
                if (r_rd_data != r_cfg.end_marker) begin
                    n_k     = FW'(1);
                    n_state = ST_RSA;
                end else if (!r_hold_v || out_free) begin
                    if (r_hold_v) begin
                        n_ov   = 1'b1;
                        n_kind = KIND_FRAME;
                        n_fs   = r_hold_start;
                        n_fl   = r_hold_len;
                        n_rb   = '0;
                        n_of   = r_ovf;
                        n_last = 1'b0;
                    end
                    n_hold_v     = 1'b1;
                    n_hold_start = 9'(r_head);
                    n_hold_len   = r_len;
                    n_head       = r_head + AW'(r_len);
                    n_fill       = r_fill - FW'(r_len);
                    n_cnt        = r_cnt + CW'(1);
                    n_state      = ST_CHK;
                end
            end
            ST_RSA: begin
                if (r_k >= r_fill) begin
                    n_fill  = '0;
                    n_state = ST_CHK;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_head + r_k[AW-1:0];
                    n_state   = ST_RSB;
                end
            end
            ST_RSB: begin
                if (r_rd_data == r_cfg.start_marker) begin
                    n_head  = r_head + r_k[AW-1:0];
                    n_fill  = r_fill - r_k;
                    n_state = ST_CHK;
                end else begin
                    n_k     = r_k + FW'(1);
                    n_state = ST_RSA;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_ov   = 1'b1;
                    n_kind = r_hold_v ? KIND_FRAME : KIND_NONE;
                    n_fs   = r_hold_v ? r_hold_start : 9'd0;
                    n_fl   = r_hold_v ? r_hold_len : 9'd0;
                    n_rb   = '0;
                    n_of   = r_ovf;
                    n_last = 1'b1;
                    n_hold_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_fill   <= '0;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_hold_v <= n_hold_v;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_len        <= n_len;
        r_hold_start <= n_hold_start;
        r_hold_len   <= n_hold_len;
        r_kind       <= n_kind;
        r_fs         <= n_fs;
        r_fl         <= n_fl;
        r_rb         <= n_rb;
        r_of         <= n_of;
        r_last       <= n_last;
    end

endmodule

FILE: src/sof_length_eof_deframer.sv
// channel  | handshake          | fields
// ---------+--------------------+-----------------------------------------------
// input    | i_valid / o_ready  | i_req_type, i_data_byte, i_read_offset
// result   | o_valid / i_ready  | o_result_kind, o_frame_start, o_frame_length,
//          |                    | o_read_byte, o_overflow_cleared, o_last_result
// config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// Reads and pushes are handled one at a time. A push scans for frames, steps
// over non-start heads, walks resync searches and checks lengths, each read
// of the ring going through its one read port. A 2-word queue lets input
// words arrive while a result waits. Synchronous active-low reset; the ring
// is not cleared.
module sof_length_eof_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_req_type,
    input  logic [7:0] i_data_byte,
    input  logic [8:0] i_read_offset,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_result_kind,
    output logic [8:0] o_frame_start,
    output logic [8:0] o_frame_length,
    output logic [7:0] o_read_byte,
    output logic       o_overflow_cleared,
    output logic       o_last_result
);
    import sled_pkg::*;

    logic q_valid, q_pop;
    t_cmd q_cmd;

    sled_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_data_byte   (i_data_byte),
        .i_read_offset (i_read_offset),
        .o_q_valid     (q_valid),
        .o_q_cmd       (q_cmd),
        .i_q_pop       (q_pop)
    );

    sled_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_q_valid          (q_valid),
        .i_q_cmd            (q_cmd),
        .o_q_pop            (q_pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_result_kind      (o_result_kind),
        .o_frame_start      (o_frame_start),
        .o_frame_length     (o_frame_length),
        .o_read_byte        (o_read_byte),
        .o_overflow_cleared (o_overflow_cleared),
        .o_last_result      (o_last_result)
    );

endmodule

FILE: src/sled_checker.sv
module sled_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_result_kind,
    input logic [8:0] o_frame_start,
    input logic [8:0] o_frame_length,
    input logic       o_overflow_cleared,
    input logic       o_last_result
);
    import sled_pkg::*;

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result_kind == KIND_NONE || o_result_kind == KIND_FRAME
                     || o_result_kind == KIND_READ))
        else $error("illegal result kind");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == KIND_READ || o_result_kind == KIND_NONE)
        |-> o_last_result)
        else $error("read or empty result not last");

    a_read_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_READ |-> !o_overflow_cleared)
        else $error("read result flags overflow");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frame_start)
                                && $stable(o_frame_length))
        else $error("stalled result changed");

endmodule

bind sof_length_eof_deframer sled_checker u_sled_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_result_kind      (o_result_kind),
    .o_frame_start      (o_frame_start),
    .o_frame_length     (o_frame_length),
    .o_overflow_cleared (o_overflow_cleared),
    .o_last_result      (o_last_result)
);

FILE: dv/tb_sof_length_eof_deframer.sv
`timescale 1ns / 1ps

module tb_sof_length_eof_deframer;
    import sled_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [8:0] fstart;
        logic [8:0] flen;
        logic [7:0] rbyte;
        logic       ovf;
        logic       last;
    } t_res;

    typedef struct {
        logic       is_read;
        logic [7:0] data;
        logic [8:0] offs;
        logic       has_exp;
        t_res       exp;
    } t_row;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_cfg_we = 0;
    logic [1:0] i_cfg_idx = 0;
    logic [7:0] i_cfg_data = 0;
    logic       i_valid = 0;
    logic       o_ready;
    logic       i_req_type = 0;
    logic [7:0] i_data_byte = 0;
    logic [8:0] i_read_offset = 0;
    logic       o_valid;
    logic       i_ready = 0;
    logic [1:0] o_result_kind;
    logic [8:0] o_frame_start;
    logic [8:0] o_frame_length;
    logic [7:0] o_read_byte;
    logic       o_overflow_cleared;
    logic       o_last_result;

    sof_length_eof_deframer dut (.*);

    always #5 i_clk = ~i_clk;

    logic [7:0] mdl_sof, mdl_eof;
    logic [6:0] mdl_ovh;
    logic [7:0] mdl_ring [BUF_DEPTH];
    bit         mdl_written [BUF_DEPTH];
    int         mdl_head, mdl_fill;

    t_res exp_results[$];
    int   errors = 0, n_frames = 0, n_reads = 0, n_words = 0, n_ovf = 0;
    int   cycles = 0;
    bit   recv_on = 0;

    function automatic int rpos(int off);
        return (mdl_head + off) % BUF_DEPTH;
    endfunction

    function automatic void resync_head();
        for (int k = 1; k < mdl_fill; k++) begin
            if (mdl_ring[rpos(k)] == mdl_sof) begin
                mdl_head = rpos(k);
                mdl_fill -= k;
                return;
            end
        end
        mdl_fill = 0;
    endfunction

    function automatic void predict_word(logic is_read, logic [7:0] d, logic [8:0] offs);
        t_res r;
        int   n;
        int   len;
        logic ovf;
        n = 0;
        ovf = 0;
        r = '0;
        if (is_read) begin
            r.kind = KIND_READ;
            r.rbyte = mdl_ring[offs];
            r.last = 1;
            exp_results.push_back(r);
            return;
        end
        if (mdl_fill >= BUF_DEPTH) begin
            mdl_fill = 0;
            ovf = 1;
        end
        mdl_ring[rpos(mdl_fill)] = d;
        mdl_written[rpos(mdl_fill)] = 1;
        mdl_fill++;
        while (mdl_fill > 2 && n < MAX_RESULTS) begin
            if (mdl_ring[mdl_head] != mdl_sof) begin
                resync_head();
                continue;
            end
            len = mdl_ring[rpos(1)] + mdl_ovh;
            if (len > mdl_fill) break;
            if (len != 0 && mdl_ring[rpos(len - 1)] == mdl_eof) begin
                r = '0;
                r.kind = KIND_FRAME;
                r.fstart = 9'(mdl_head);
                r.flen = 9'(len);
                r.ovf = ovf;
                exp_results.push_back(r);
                n++;
                mdl_head = rpos(len);
                mdl_fill -= len;
            end else begin
                resync_head();
            end
        end
        if (n == 0) begin
            r = '0;
            r.kind = KIND_NONE;
            r.ovf = ovf;
            exp_results.push_back(r);
        end
        r = exp_results.pop_back();
        r.last = 1;
        exp_results.push_back(r);
    endfunction

    // receiver with random stalls
    initial begin
        int gap;
        t_res got, want;
        forever begin
            @(posedge i_clk);
            if (!recv_on) continue;
            gap = $urandom_range(0, 18);
            if ($urandom_range(0, 3) == 0) gap = 0;
            repeat (gap) @(posedge i_clk);
            i_ready <= 1;
            do @(posedge i_clk); while (!o_valid);
            i_ready <= 0;
            got = '{o_result_kind, o_frame_start, o_frame_length, o_read_byte,
                    o_overflow_cleared, o_last_result};
            if (exp_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = exp_results.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch exp kind%0d st%0d len%0d rb%0h ov%0b l%0b",
                                  " got kind%0d st%0d len%0d rb%0h ov%0b l%0b"},
                            want.kind, want.fstart, want.flen, want.rbyte, want.ovf,
                            want.last, got.kind, got.fstart, got.flen, got.rbyte,
                            got.ovf, got.last);
                end
                if (want.kind == KIND_FRAME) n_frames++;
                if (want.ovf) n_ovf++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_word(logic is_read, logic [7:0] d, logic [8:0] offs);
        int gap;
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_req_type <= is_read;
        i_data_byte <= d;
        i_read_offset <= offs;
        do @(posedge i_clk); while (!o_ready);
        predict_word(is_read, d, offs);
        n_words++;
        if (is_read) n_reads++;
    endtask

    task automatic drain();
        i_valid <= 0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [7:0] v);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_START_MARKER: mdl_sof = v;
            CFG_END_MARKER:   mdl_eof = v;
            CFG_OVERHEAD:     mdl_ovh = v[6:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic check_row(t_row row);
        send_word(row.is_read, row.data, row.offs);
        if (row.has_exp && exp_results.size() > 0 && exp_results[$] !== row.exp) begin
            errors++;
            if (errors <= 10) $display("directed row expectation differs from predictor");
        end
    endtask

    task automatic send_frame(int body, bit good);
        int len;
        len = body + mdl_ovh;
        send_word(0, mdl_sof, 9'd0);
        send_word(0, body[7:0], 9'd0);
        for (int k = 2; k < len - 1; k++) send_word(0, 8'($urandom_range(0, 255)), 9'd0);
        send_word(0, good ? mdl_eof : mdl_eof ^ 8'h01, 9'd0);
    endtask

    task automatic send_read();
        int idx;
        idx = $urandom_range(0, BUF_DEPTH - 1);
        for (int t = 0; t < BUF_DEPTH && !mdl_written[idx]; t++) idx = (idx + 1) % BUF_DEPTH;
        if (mdl_written[idx]) send_word(1, 8'($urandom_range(0, 255)), 9'(idx));
    endtask

    t_row dir_rows[$];

    initial begin
        t_row row;
        mdl_sof = 222;
        mdl_eof = 202;
        mdl_ovh = 24;
        mdl_head = 0;
        mdl_fill = 0;
        foreach (mdl_ring[i]) begin
            mdl_ring[i] = 0;
            mdl_written[i] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        recv_on = 1;

        write_cfg(CFG_START_MARKER, 8'hA5);
        write_cfg(CFG_END_MARKER, 8'h5A);
        write_cfg(CFG_OVERHEAD, 8'd8);
        write_cfg(CFG_UNUSED, 8'hFF);

        // directed: noise bytes give kind 0, then a minimum frame, reads
        row = '{0, 8'h00, 9'h000, 1, '{KIND_NONE, 0, 0, 0, 0, 1}};
        dir_rows.push_back(row);
        row = '{0, 8'hFF, 9'h1FF, 1, '{KIND_NONE, 0, 0, 0, 0, 1}};
        dir_rows.push_back(row);
        row = '{0, 8'h11, 9'h000, 1, '{KIND_NONE, 0, 0, 0, 0, 1}};
        dir_rows.push_back(row);
        dir_rows.push_back('{0, 8'hA5, 0, 0, '0});
        dir_rows.push_back('{0, 8'h00, 0, 0, '0});
        for (int k = 0; k < 5; k++) dir_rows.push_back('{0, 8'hA5, 0, 0, '0});
        dir_rows.push_back('{0, 8'h5A, 0, 0, '0});
        dir_rows.push_back('{1, 8'hFF, 9'h000, 0, '0});
        dir_rows.push_back('{1, 8'h00, 9'h001, 0, '0});
        dir_rows.push_back('{1, 8'h00, 9'h002, 0, '0});
        // broken frame: wrong end byte
        dir_rows.push_back('{0, 8'hA5, 0, 0, '0});
        dir_rows.push_back('{0, 8'h00, 0, 0, '0});
        for (int k = 0; k < 6; k++) dir_rows.push_back('{0, 8'h33, 0, 0, '0});
        foreach (dir_rows[i]) check_row(dir_rows[i]);
        drain();

        // hold-off until all results are back, then random frames (some with a bad end byte), noise and reads
        write_cfg(CFG_START_MARKER, 8'hDE);
        write_cfg(CFG_END_MARKER, 8'hCA);
        write_cfg(CFG_OVERHEAD, 8'd8);
        repeat (4) begin
            if ($urandom_range(0, 3) == 0) send_word(0, 8'($urandom_range(0, 255)), 9'd0);
            else send_frame($urandom_range(0, 3), $urandom_range(0, 4) != 0);
            if ($urandom_range(0, 1)) send_read();
        end
        drain();

        write_cfg(CFG_START_MARKER, 8'h00);
        write_cfg(CFG_END_MARKER, 8'hFF);
        write_cfg(CFG_OVERHEAD, 8'd9);
        repeat (2) begin
            send_frame($urandom_range(0, 2), $urandom_range(0, 3) != 0);
            send_read();
        end
        send_word(0, 8'($urandom), 9'd0);
        drain();

        // overhead of 64, one long frame
        write_cfg(CFG_START_MARKER, 8'hFF);
        write_cfg(CFG_END_MARKER, 8'h00);
        write_cfg(CFG_OVERHEAD, 8'd64);
        send_frame(0, 1);
        send_read();
        drain();

        $display("words %0d, reads %0d, frames %0d, overflow flags %0d",
                 n_words, n_reads, n_frames, n_ovf);
        $display("marker and overhead settings swept incl. extremes, checked after %0d cycles",
                 cycles);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: sim.f
src/sled_pkg.sv
src/sled_front.sv
src/sled_back.sv
src/sof_length_eof_deframer.sv
src/sled_checker.sv
dv/tb_sof_length_eof_deframer.sv
